### rtl/core/eeg_pkg.sv
// Package for the extended Euclid GCD core: widths, microcode types and the
// program ROM of the sequencer. No dependencies.
`timescale 1ns / 1ps

package eeg_pkg;

    localparam int EEG_WIDTH = 32;
    localparam int PC_W      = 3;

    // Datapath operations selected by the control word.
    typedef enum logic [2:0] {
        OP_NOP      = 3'd0,
        OP_LOAD     = 3'd1,
        OP_DIV_INIT = 3'd2,
        OP_DIV_STEP = 3'd3,
        OP_UPDATE   = 3'd4,
        OP_FINISH   = 3'd5
    } t_op;

    // Sequencing rules for the step counter.
    typedef enum logic [2:0] {
        JMP_NEXT     = 3'd0,
        JMP_GOTO     = 3'd1,
        JMP_WAIT_IN  = 3'd2,
        JMP_IF_R1Z   = 3'd3,
        JMP_LOOP_DIV = 3'd4,
        JMP_WAIT_OUT = 3'd5
    } t_jmp;

    typedef struct packed {
        t_op             op;
        t_jmp            jmp;
        logic [PC_W-1:0] target;
    } t_uword;

    // Control handed from the sequencer to the datapath.
    typedef struct packed {
        t_op  op;
        logic in_rdy;
    } t_ctrl;

    // Status handed from the datapath back to the sequencer.
    typedef struct packed {
        logic in_fire;
        logic r1_zero;
        logic div_last;
        logic out_free;
    } t_status;

    localparam logic [PC_W-1:0] STEP_LOAD     = 3'd0;
    localparam logic [PC_W-1:0] STEP_TEST     = 3'd1;
    localparam logic [PC_W-1:0] STEP_DIV_INIT = 3'd2;
    localparam logic [PC_W-1:0] STEP_DIV      = 3'd3;
    localparam logic [PC_W-1:0] STEP_UPDATE   = 3'd4;
    localparam logic [PC_W-1:0] STEP_FINISH   = 3'd5;

    function automatic t_uword prog_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_NOP, jmp: JMP_GOTO, target: STEP_LOAD};
        unique case (pc)
            STEP_LOAD:     w = '{op: OP_LOAD,     jmp: JMP_WAIT_IN,  target: STEP_LOAD};
            STEP_TEST:     w = '{op: OP_NOP,      jmp: JMP_IF_R1Z,   target: STEP_FINISH};
            STEP_DIV_INIT: w = '{op: OP_DIV_INIT, jmp: JMP_NEXT,     target: STEP_LOAD};
            STEP_DIV:      w = '{op: OP_DIV_STEP, jmp: JMP_LOOP_DIV, target: STEP_DIV};
            STEP_UPDATE:   w = '{op: OP_UPDATE,   jmp: JMP_GOTO,     target: STEP_TEST};
            STEP_FINISH:   w = '{op: OP_FINISH,   jmp: JMP_WAIT_OUT, target: STEP_LOAD};
            default:       w = '{op: OP_NOP,      jmp: JMP_GOTO,     target: STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage

### rtl/core/eeg_in_if.sv
// Input channel of the extended Euclid GCD core: valid/ready plus operands.
// Depends on eeg_pkg for the default width.
`timescale 1ns / 1ps

interface eeg_in_if
    import eeg_pkg::*;
#(
    parameter int WIDTH = EEG_WIDTH
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] operand_a;
    logic [WIDTH-1:0] operand_b;

    modport source (output valid, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

### rtl/core/eeg_out_if.sv
// Output channel of the extended Euclid GCD core: valid/ready plus the GCD
// and both Bezout coefficients. Depends on eeg_pkg for the default width.
`timescale 1ns / 1ps

interface eeg_out_if
    import eeg_pkg::*;
#(
    parameter int WIDTH = EEG_WIDTH
);
    logic               valid;
    logic               ready;
    logic [WIDTH-1:0]   gcd_value;
    logic signed [WIDTH:0] coef_large;
    logic signed [WIDTH:0] coef_small;

    modport source (output valid, output gcd_value, output coef_large, output coef_small,
                    input ready);
    modport sink   (input valid, input gcd_value, input coef_large, input coef_small,
                    output ready);
endinterface

### rtl/core/extended_euclid_gcd_core.sv
// Extended Euclid GCD core, top level: remainder/coefficient datapath with a
// bit-serial divider, run by eeg_seq. Depends on eeg_pkg, eeg_in_if, eeg_out_if.
//
//   port   | direction | carries
//   -------+-----------+------------------------------------------------
//   i_in   | sink      | operand_a, operand_b (WIDTH bits, unsigned)
//   o_out  | source    | gcd_value (WIDTH), coef_large, coef_small (WIDTH+1, signed)
//
// In each Euclid step the restoring divider resolves one quotient bit per
// cycle and accumulates q*s and q*t alongside it. Reset is synchronous,
// active low, holds the input ready low and returns the sequencer to its load
// step. The result sits in an output register, so the next operands are taken
// while it waits; a result stalled by the sink holds the sequencer only when
// the next one is ready.
`timescale 1ns / 1ps

module extended_euclid_gcd_core
    import eeg_pkg::*;
#(
    parameter int WIDTH = EEG_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    eeg_in_if.sink     i_in,
    eeg_out_if.source  o_out
);

    localparam int CW   = WIDTH + 1;
    localparam int CNTW = $clog2(WIDTH);

    t_ctrl   ctrl;
    t_status status;

    logic [WIDTH-1:0] r_r0, r_r1, r_rem, r_dvd;
    logic [CW-1:0]    r_s0, r_s1, r_t0, r_t1, r_ps, r_pt;
    logic [CNTW-1:0]  r_cnt;

    logic             r_out_valid;
    logic [WIDTH-1:0] r_gcd;
    logic [CW-1:0]    r_cl, r_cs;

    logic             in_fire, out_free, fin_fire;
    logic             a_lt_b;
    logic [WIDTH:0]   trial;
    logic             qbit;
    logic [WIDTH:0]   trial_sub;

    eeg_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign fin_fire = (ctrl.op == OP_FINISH) && out_free;

    assign status.in_fire  = in_fire;
    assign status.r1_zero  = (r_r1 == '0);
    assign status.div_last = (r_cnt == CNTW'(WIDTH - 1));
    assign status.out_free = out_free;

    assign a_lt_b = (i_in.operand_a < i_in.operand_b);

    // Restoring division, most significant dividend bit first.
    assign trial     = {r_rem, r_dvd[WIDTH-1]};
    assign qbit      = (trial >= {1'b0, r_r1});
    assign trial_sub = trial - {1'b0, r_r1};

    always_ff @(posedge i_clk) begin
        unique case (ctrl.op)
            OP_LOAD: begin
                if (in_fire) begin
                    r_r0 <= a_lt_b ? i_in.operand_b : i_in.operand_a;
                    r_r1 <= a_lt_b ? i_in.operand_a : i_in.operand_b;
                    r_s0 <= CW'(1);
                    r_s1 <= '0;
                    r_t0 <= '0;
                    r_t1 <= CW'(1);
                end
            end
            OP_DIV_INIT: begin
                r_rem <= '0;
                r_dvd <= r_r0;
                r_ps  <= '0;
                r_pt  <= '0;
                r_cnt <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= qbit ? trial_sub[WIDTH-1:0] : trial[WIDTH-1:0];
                r_dvd <= {r_dvd[WIDTH-2:0], 1'b0};
                // Horner accumulation of q*s1 and q*t1, modulo 2^CW.
                r_ps  <= {r_ps[CW-2:0], 1'b0} + (qbit ? r_s1 : '0);
                r_pt  <= {r_pt[CW-2:0], 1'b0} + (qbit ? r_t1 : '0);
                r_cnt <= r_cnt + 1'b1;
            end
            OP_UPDATE: begin
                r_r0 <= r_r1;
                r_r1 <= r_rem;
                r_s0 <= r_s1;
                r_s1 <= r_s0 - r_ps;
                r_t0 <= r_t1;
                r_t1 <= r_t0 - r_pt;
            end
            OP_NOP, OP_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (fin_fire) begin
            r_gcd <= r_r0;
            r_cl  <= r_s0;
            r_cs  <= r_t0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign i_in.ready       = ctrl.in_rdy && i_rst_n;
    assign o_out.valid      = r_out_valid;
    assign o_out.gcd_value  = r_gcd;
    assign o_out.coef_large = $signed(r_cl);
    assign o_out.coef_small = $signed(r_cs);

endmodule

### rtl/core/eeg_seq.sv
// Microcode sequencer: step counter, program ROM from eeg_pkg and the jump
// logic. Drives the datapath control word and takes its status back.
`timescale 1ns / 1ps

module eeg_seq
    import eeg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic [PC_W-1:0] pc_inc;
    t_uword          uw;

    assign uw     = prog_rom(r_pc);
    assign pc_inc = r_pc + 1'b1;

    always_comb begin
        unique case (uw.jmp)
            JMP_NEXT:     n_pc = pc_inc;
            JMP_GOTO:     n_pc = uw.target;
            JMP_WAIT_IN:  n_pc = i_status.in_fire  ? pc_inc    : r_pc;
            JMP_IF_R1Z:   n_pc = i_status.r1_zero  ? uw.target : pc_inc;
            JMP_LOOP_DIV: n_pc = i_status.div_last ? pc_inc    : uw.target;
            JMP_WAIT_OUT: n_pc = i_status.out_free ? uw.target : r_pc;
            default:      n_pc = STEP_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.op     = uw.op;
    assign o_ctrl.in_rdy = (uw.op == OP_LOAD);

endmodule

### rtl/core/eeg_check.sv
// Port-level checker for the extended Euclid GCD core and its bind onto the
// top level. Depends on eeg_pkg for the default width.
`timescale 1ns / 1ps

module eeg_check
    import eeg_pkg::*;
#(
    parameter int WIDTH = EEG_WIDTH
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [WIDTH-1:0]      i_gcd_value,
    input logic signed [WIDTH:0] i_coef_large,
    input logic signed [WIDTH:0] i_coef_small
);

    logic       in_acc, out_acc;
    logic [1:0] r_pending;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Transactions taken in but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_acc && !out_acc) begin
            r_pending <= r_pending + 1'b1;
        end else if (out_acc && !in_acc) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_gcd_value) && $stable(i_coef_large) && $stable(i_coef_small))
        else $error("stalled result changed");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (r_pending != 2'd0))
        else $error("result delivered without a pending transaction");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("more than two transactions in flight");

    a_zero_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_gcd_value == '0) |->
            (i_coef_large == (WIDTH+1)'(1)) && (i_coef_small == '0))
        else $error("zero gcd with wrong coefficients");

endmodule

bind extended_euclid_gcd_core eeg_check #(.WIDTH(WIDTH)) u_eeg_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_gcd_value  (o_out.gcd_value),
    .i_coef_large (o_out.coef_large),
    .i_coef_small (o_out.coef_small)
);

### bench/extended_euclid_gcd_core_tb.sv
// Self-checking testbench for extended_euclid_gcd_core: random and directed
// operand pairs, with the GCD and Bezout coefficients predicted in the bench.
// Depends on eeg_pkg, eeg_in_if, eeg_out_if and the core itself.
`timescale 1ns / 1ps

module extended_euclid_gcd_core_tb
    import eeg_pkg::*;
;

    localparam int WIDTH        = EEG_WIDTH;
    localparam int RANDOM_ITEMS = 400;
    // 32-bit operands need at most 45 Euclid steps, so DRAIN_CYCLES covers the
    // longest single transaction.
    localparam int DRAIN_CYCLES = 2000;
    localparam int CYCLE_LIMIT  = 3_000_000;

    typedef struct packed {
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
    } operand_pair_t;

    typedef struct packed {
        logic [WIDTH-1:0]    gcd_value;
        logic signed [WIDTH:0] coef_large;
        logic signed [WIDTH:0] coef_small;
    } bezout_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    eeg_in_if  #(.WIDTH(WIDTH)) in_ch ();
    eeg_out_if #(.WIDTH(WIDTH)) out_ch ();

    extended_euclid_gcd_core #(.WIDTH(WIDTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    operand_pair_t operand_pairs[$];
    bezout_t       bezout_expected[$];
    int            pairs_total    = 0;
    int            pairs_accepted = 0;
    int            errors         = 0;
    int            cycle_count    = 0;
    logic          in_taken       = 1'b0;
    int            in_gap         = 0;
    bit            in_burst       = 1'b0;
    int            out_stall      = 0;
    bit            out_burst      = 1'b0;

    // Remainder sequence with the coefficients carried modulo 2^64; the true
    // values are far smaller, so the low WIDTH+1 bits are exact.
    function automatic bezout_t bezout_predict(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y);
        logic [63:0] r_prev, r_cur, s_prev, s_cur, t_prev, t_cur;
        logic [63:0] quot, r_next, s_next, t_next;
        bezout_t     res;
        if (x < y) begin
            r_prev = 64'(y);
            r_cur  = 64'(x);
        end else begin
            r_prev = 64'(x);
            r_cur  = 64'(y);
        end
        s_prev = 64'd1;
        s_cur  = 64'd0;
        t_prev = 64'd0;
        t_cur  = 64'd1;
        while (r_cur != 64'd0) begin
            quot   = r_prev / r_cur;
            r_next = r_prev - quot * r_cur;
            s_next = s_prev - quot * s_cur;
            t_next = t_prev - quot * t_cur;
            r_prev = r_cur;
            r_cur  = r_next;
            s_prev = s_cur;
            s_cur  = s_next;
            t_prev = t_cur;
            t_cur  = t_next;
        end
        res.gcd_value  = r_prev[WIDTH-1:0];
        res.coef_large = s_prev[WIDTH:0];
        res.coef_small = t_prev[WIDTH:0];
        return res;
    endfunction

    function automatic logic [WIDTH-1:0] fib(input int n);
        logic [63:0] f0, f1, f2;
        f0 = 64'd0;
        f1 = 64'd1;
        for (int i = 1; i < n; i++) begin
            f2 = f0 + f1;
            f0 = f1;
            f1 = f2;
        end
        return f1[WIDTH-1:0];
    endfunction

    function automatic logic [WIDTH-1:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[WIDTH-1:0];
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    function automatic void add_pair(input logic [WIDTH-1:0] a, input logic [WIDTH-1:0] b);
        operand_pair_t p;
        p.a = a;
        p.b = b;
        operand_pairs = {operand_pairs, p};
    endfunction

    // Random operand pairs. Consecutive Fibonacci numbers give the longest
    // remainder chains; products of a shared factor give gcd values above one.
    task automatic fill_random();
        logic [WIDTH-1:0] ones, g, a, b;
        int n;
        ones = '1;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            a = rand_word();
            b = rand_word();
            case ($urandom_range(0, 9))
                0, 1, 2: ;
                3, 4: begin
                    g = WIDTH'($urandom_range(2, 65535));
                    a = g * WIDTH'($urandom_range(0, 32'(ones / g)));
                    b = g * WIDTH'($urandom_range(0, 32'(ones / g)));
                end
                5: begin
                    n = $urandom_range(2, 46);
                    a = fib(n + 1);
                    b = fib(n);
                    if ($urandom_range(0, 1)) begin
                        a = fib(n);
                        b = fib(n + 1);
                    end
                end
                6: begin
                    a = a >> $urandom_range(0, WIDTH - 1);
                    b = b >> $urandom_range(0, WIDTH - 1);
                end
                7: begin
                    a = WIDTH'($urandom_range(0, 255));
                    b = WIDTH'($urandom_range(0, 255));
                end
                8: begin
                    if ($urandom_range(0, 1)) a = '0;
                    else b = a;
                end
                default: begin
                    b = b >> $urandom_range(8, WIDTH - 1);
                    a = b * WIDTH'($urandom_range(1, 200));
                end
            endcase
            add_pair(a, b);
        end
    endtask

    // Input driver: a transaction holds until it is taken, then a gap may follow.
    always @(negedge i_clk) begin : operand_driver
        operand_pair_t p;
        if (!i_rst_n) begin
            in_ch.valid     <= 1'b0;
            in_ch.operand_a <= '0;
            in_ch.operand_b <= '0;
        end else if (!in_ch.valid || in_taken) begin
            if (in_gap > 0) begin
                in_ch.valid <= 1'b0;
                in_gap      <= in_gap - 1;
            end else if (operand_pairs.size() > 0) begin
                p = operand_pairs.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.operand_a <= p.a;
                in_ch.operand_b <= p.b;
                if ($urandom_range(0, 24) == 0) in_burst <= !in_burst;
                in_gap <= in_burst ? 0 : pick_gap();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result sink back-pressure.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 499) == 0) out_burst <= !out_burst;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (out_stall > 0) begin
            out_ch.ready <= 1'b0;
            out_stall    <= out_stall - 1;
        end else if (!out_burst && $urandom_range(0, 99) < 30) begin
            out_ch.ready <= 1'b0;
            out_stall    <= pick_gap();
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        in_taken    <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            bezout_expected = {bezout_expected,
                               bezout_predict(in_ch.operand_a, in_ch.operand_b)};
            pairs_accepted <= pairs_accepted + 1;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        bezout_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (bezout_expected.size() == 0) begin
                $error("unexpected result transaction: gcd_value %0d", out_ch.gcd_value);
                errors++;
            end else begin
                want = bezout_expected.pop_front();
                if (out_ch.gcd_value !== want.gcd_value) begin
                    $error("gcd_value: expected %0d, got %0d", want.gcd_value,
                           out_ch.gcd_value);
                    errors++;
                end
                if (out_ch.coef_large !== want.coef_large) begin
                    $error("coef_large: expected %0d, got %0d", want.coef_large,
                           out_ch.coef_large);
                    errors++;
                end
                if (out_ch.coef_small !== want.coef_small) begin
                    $error("coef_small: expected %0d, got %0d", want.coef_small,
                           out_ch.coef_small);
                    errors++;
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [WIDTH-1:0] ones;
        ones = '1;

        // Zero operands, equal operands, extremes and the slowest chains.
        add_pair('0, '0);
        add_pair(WIDTH'(123), '0);
        add_pair('0, ones);
        add_pair(ones, ones);
        add_pair(WIDTH'(77), WIDTH'(77));
        add_pair(WIDTH'(1), WIDTH'(1));
        add_pair(ones, WIDTH'(1));
        add_pair(WIDTH'(1), ones);
        add_pair(ones, ones - 1'b1);
        add_pair(fib(47), fib(46));
        add_pair(fib(46), fib(47));
        add_pair({1'b1, {(WIDTH-1){1'b0}}}, {2'b01, {(WIDTH-2){1'b0}}});
        add_pair({(WIDTH/2){2'b01}}, {(WIDTH/2){2'b10}});
        add_pair(WIDTH'(240), WIDTH'(46));
        add_pair(WIDTH'(46), WIDTH'(240));
        add_pair(WIDTH'(1000), WIDTH'(10));
        add_pair(ones, {1'b1, {(WIDTH-1){1'b0}}});
        add_pair(WIDTH'(2), WIDTH'(3));
        add_pair(WIDTH'(6), WIDTH'(4));
        add_pair(ones - 1'b1, '0);
        fill_random();
        pairs_total = operand_pairs.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pairs_accepted < pairs_total || bezout_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
